FILE: hw/rtl/shsp_pkg.sv
// shsp_pkg: shared types, constants and the half-step coil table for the
// stepper half-step positioner. no dependencies.
`default_nettype none

package shsp_pkg;

    // geometry
    localparam int unsigned FULL_TRAVEL_STEPS = 2048;
    localparam int unsigned POS_W             = 12;
    localparam int unsigned PHASE_W           = 3;
    localparam int unsigned COIL_W            = 4;
    localparam int unsigned PCT_W             = 8;
    localparam int unsigned SAT_PCT_W         = 7;
    localparam int unsigned PCT_MAX           = 100;

    // floor(pct * FULL_TRAVEL_STEPS / 100) as one constant multiply and a shift;
    // reciprocal error times the largest product stays below 2^RECIP_SHIFT
    localparam int unsigned     RECIP_SHIFT = 27;
    localparam longint unsigned RECIP_MULT  =
        ((64'd1 << RECIP_SHIFT) + PCT_MAX - 1) / PCT_MAX;
    localparam longint unsigned TGT_MULT    = FULL_TRAVEL_STEPS * RECIP_MULT;
    localparam int unsigned     PROD_W      = 40;

    // item kinds
    typedef enum logic {
        MODE_SET  = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   target;
        logic [PHASE_W-1:0] phase;
        logic [COIL_W-1:0]  coils;
    } motor_state_t;

    typedef struct packed {
        logic [COIL_W-1:0] coils;
        logic [POS_W-1:0]  position;
        logic              stepped;
    } step_result_t;

    // half-step pattern, bit0 is coil one
    function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'h1;
            3'd1:    pat = 4'h3;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'hC;
            3'd6:    pat = 4'h8;
            3'd7:    pat = 4'h9;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/shsp_step_logic.sv
// shsp_step_logic: next motor state and result for one item, purely
// combinational. depends on shsp_pkg.
`default_nettype none

module shsp_step_logic
    import shsp_pkg::*;
(
    input  wire logic               mode,
    input  wire logic [PCT_W-1:0]   percent,
    input  wire motor_state_t       state_cur,
    output motor_state_t            state_next,
    output step_result_t            result
);

    logic [SAT_PCT_W-1:0] sat_pct;
    logic [PROD_W-1:0]    prod;
    logic                 do_step;
    logic                 step_up;
    logic [PHASE_W-1:0]   phase_new;

    // saturate and scale the percentage
    assign sat_pct = (percent > PCT_W'(PCT_MAX)) ? SAT_PCT_W'(PCT_MAX)
                                                 : percent[SAT_PCT_W-1:0];
    assign prod    = PROD_W'(sat_pct) * PROD_W'(TGT_MULT);

    assign do_step   = (mode_t'(mode) == MODE_TICK) &&
                       (state_cur.position != state_cur.target);
    assign step_up   = state_cur.position < state_cur.target;
    assign phase_new = step_up ? state_cur.phase + PHASE_W'(1)
                               : state_cur.phase - PHASE_W'(1);

    always_comb begin
        state_next = state_cur;
        if (mode_t'(mode) == MODE_SET) begin
            state_next.target = prod[RECIP_SHIFT +: POS_W];
        end else if (do_step) begin
            if (step_up) begin
                state_next.position = state_cur.position + POS_W'(1);
            end else if (state_cur.position != '0) begin
                state_next.position = state_cur.position - POS_W'(1);
            end
            state_next.phase = phase_new;
            state_next.coils = coil_pattern(phase_new);
        end
    end

    always_comb begin
        result.coils    = state_next.coils;
        result.position = state_next.position;
        result.stepped  = do_step;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/stepper_half_step_positioner_core.sv
// stepper_half_step_positioner_core: top level of the half-step positioner,
// input register, state registers and result register. depends on shsp_pkg
// and shsp_step_logic.
//
//  channel | ports          | tdata (low bit up)                           | tuser
//  --------+----------------+----------------------------------------------+-----------
//  input   | s_tvalid/ready | percent[7:0]                                 | mode
//  result  | m_tvalid/ready | coils[3:0], position[15:4], stepped[16], pad | (none)
//
// one item per cycle sustained while m_tready keeps the result register moving;
// an item passes from the input register to the result register before its
// result is offered. the motor state is updated when an item leaves the input
// register, so a tick always sees the state left by the item before it
// aresetn (synchronous, active low) clears state, phase and coils to zero
// a stalled result register holds both stages; s_tready falls only when both
// stages are full and m_tready is low
`default_nettype none

module stepper_half_step_positioner_core
    import shsp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // percent[7:0]
    input  wire logic        s_tuser,   // mode: 0 set target, 1 step tick
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // coils[3:0], position[15:4], stepped[16]
);

    // input register
    logic               in_valid_reg;
    logic               mode_reg;
    logic [PCT_W-1:0]   percent_reg;

    // motor state
    motor_state_t       state_reg;
    motor_state_t       state_next;

    // result register
    logic               out_valid_reg;
    step_result_t       result_reg;
    step_result_t       result_next;

    logic               out_adv;
    logic               in_adv;
    logic               s_xfer;

    // a stage moves on when it is empty or its consumer takes from it
    assign out_adv  = !out_valid_reg || m_tready;
    assign in_adv   = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;
    assign s_xfer   = s_tvalid && s_tready;

    shsp_step_logic u_step (
        .mode       (mode_reg),
        .percent    (percent_reg),
        .state_cur  (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            mode_reg    <= s_tuser;
            percent_reg <= s_tdata;
        end
    end

    // motor state, updated as an item is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_adv) begin
            state_reg <= state_next;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, result_reg.stepped, result_reg.position, result_reg.coils};

`ifndef SYNTHESIS
    // the target is never beyond full travel
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.target <= POS_W'(FULL_TRAVEL_STEPS))
        else $error("target beyond full travel");

    // position only ever walks towards a legal target
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.position <= POS_W'(FULL_TRAVEL_STEPS))
        else $error("position beyond full travel");

    // a consumed tick away from target changes the position
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv && mode_reg && (state_reg.position != state_reg.target)
        |=> state_reg.position != $past(state_reg.position))
        else $error("tick off target did not move");

    // a consumed set item leaves position and coils untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_adv && !mode_reg
        |=> $stable(state_reg.position) && $stable(state_reg.coils))
        else $error("set item disturbed the motor");

    // a stepped result always drives a half-step pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.stepped |-> result_reg.coils != '0)
        else $error("step reported with all coils off");
`endif

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// testbench for stepper_half_step_positioner_core: drives set and tick items
// over the input stream and checks every result against a motor model
// kept in step here. depends on shsp_pkg and the core rtl.
`timescale 1ns / 1ps

module testbench;
    import shsp_pkg::*;

    // half-step coil patterns indexed by phase, bit0 is coil one
    localparam logic [7:0][COIL_W-1:0] HALF_STEP_COILS =
        {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

    localparam int unsigned RANDOM_ITEMS = 725;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned REPORT_LIMIT = 10;

    // one input item plus the idle time the sender leaves before it
    typedef struct {
        mode_t             mode;
        logic [PCT_W-1:0]  pct;
        int unsigned       gap;
        bit                drain;   // hold back until all results are in
    } motor_cmd_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;      // percent[7:0]
    logic        s_tuser = 1'b0;    // mode: 0 set target, 1 step tick
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // coils[3:0], position[15:4], stepped[16], pad

    motor_cmd_t   cmd_queue[$];
    step_result_t pending_results[$];

    // motor model state
    logic [POS_W-1:0]   motor_pos = '0;
    logic [POS_W-1:0]   motor_target = '0;
    logic [PHASE_W-1:0] motor_phase = '0;
    logic [COIL_W-1:0]  motor_coils = '0;

    int unsigned mismatches = 0;
    int unsigned calm_left = 0;

    stepper_half_step_positioner_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly back to back, sometimes a few cycles, now and then a long pause
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // applies one item to the motor model and returns the result it produces
    function automatic step_result_t advance_motor(input mode_t mode,
                                                   input logic [PCT_W-1:0] pct);
        int unsigned sat_pct;
        logic        moved;
        moved = 1'b0;
        if (mode == MODE_SET) begin
            // percentages above full scale saturate to full travel
            sat_pct = (pct > PCT_MAX) ? PCT_MAX : pct;
            motor_target = POS_W'((sat_pct * FULL_TRAVEL_STEPS) / PCT_MAX);
        end else if (motor_pos != motor_target) begin
            if (motor_pos < motor_target) begin
                motor_pos = motor_pos + 1'b1;
                motor_phase = motor_phase + 1'b1;
            end else begin
                // never wraps below zero
                if (motor_pos != '0)
                    motor_pos = motor_pos - 1'b1;
                motor_phase = motor_phase - 1'b1;
            end
            motor_coils = HALF_STEP_COILS[motor_phase];
            moved = 1'b1;
        end
        // a tick at target and a set item both leave coils and position held
        return '{coils: motor_coils, position: motor_pos, stepped: moved};
    endfunction

    task automatic add_item(input mode_t mode, input logic [PCT_W-1:0] pct,
                            input bit drain);
        motor_cmd_t cmd;
        cmd.mode = mode;
        cmd.pct = pct;
        cmd.drain = drain;
        // occasional runs of back-to-back transfers
        if (calm_left == 0 && $urandom_range(0, 19) == 0)
            calm_left = $urandom_range(20, 40);
        if (calm_left > 0) begin
            calm_left--;
            cmd.gap = 0;
        end else begin
            cmd.gap = pick_gap();
        end
        cmd_queue.push_back(cmd);
    endtask

    // sender: presents queued items, predicts each one as its transfer completes
    always @(posedge aclk) begin : drive_inputs
        motor_cmd_t  head;
        int unsigned wait_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            wait_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_results.push_back(advance_motor(mode_t'(s_tuser), s_tdata));
                if (cmd_queue.size() != 0)
                    wait_left = cmd_queue[0].gap;
            end
            if (s_tvalid && !s_tready) begin
                // item stays on the bus until taken
            end else if (cmd_queue.size() == 0 || wait_left > 0 ||
                         (cmd_queue[0].drain && pending_results.size() != 0)) begin
                if (wait_left > 0)
                    wait_left--;
                s_tvalid <= 1'b0;
            end else begin
                head = cmd_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= head.mode;
                s_tdata <= head.pct;
            end
        end
    end

    // receiver: random back-pressure with quiet stretches, checks every result
    always @(posedge aclk) begin : check_results
        step_result_t got;
        step_result_t want;
        int unsigned  stall_left;
        int unsigned  cycle_count;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
            cycle_count = 0;
        end else begin
            cycle_count++;
            if (m_tvalid && m_tready) begin
                got = '{coils: m_tdata[3:0], position: m_tdata[15:4],
                        stepped: m_tdata[16]};
                if (pending_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("unexpected result: coils=%h position=%0d stepped=%b",
                                 got.coils, got.position, got.stepped);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"mismatch: coils exp %h got %h, ",
                                      "position exp %0d got %0d, ",
                                      "stepped exp %b got %b"},
                                     want.coils, got.coils,
                                     want.position, got.position,
                                     want.stepped, got.stepped);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                // one quarter of the time no stalls at all
                stall_left = (cycle_count[9:8] == 2'b00) ? 0 : pick_gap();
                m_tready <= (stall_left == 0);
            end
        end
    end

    initial begin : stimulus
        mode_t       mode;
        logic [7:0]  pct;
        int unsigned r;
        int unsigned burst;
        int unsigned random_count;

        // directed: tick at reset, zero and saturated targets, upward phase wrap,
        // then back down through the wrap to zero and a tick at target
        add_item(MODE_TICK, 8'd0, 1'b0);
        add_item(MODE_SET, 8'd0, 1'b0);
        add_item(MODE_SET, 8'd255, 1'b0);
        repeat (9) add_item(MODE_TICK, 8'd0, 1'b0);
        add_item(MODE_SET, 8'd101, 1'b0);
        add_item(MODE_SET, 8'd100, 1'b0);
        add_item(MODE_SET, 8'd0, 1'b0);
        repeat (10) add_item(MODE_TICK, 8'd0, 1'b0);

        // random: mostly a new target followed by a burst of ticks, some noise;
        // the first item waits until the directed results have all arrived
        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 85) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    pct = 8'($urandom_range(0, 6));
                else if (r < 9)
                    pct = 8'($urandom_range(7, 100));
                else
                    pct = 8'($urandom_range(101, 255));
                add_item(MODE_SET, pct, random_count == 0);
                burst = $urandom_range(1, 60);
                repeat (burst) add_item(MODE_TICK, 8'($urandom), 1'b0);
                random_count += burst + 1;
            end else begin
                mode = mode_t'($urandom_range(0, 1));
                add_item(mode, 8'($urandom), random_count == 0);
                random_count++;
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_queue.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
